FILE: rtl/aesctr_pkg.sv
`timescale 1ns / 1ps
package aesctr_pkg;

    typedef logic [127:0] t_block;

    // configuration register indexes
    localparam logic [1:0] CFG_IV_LOW   = 2'd0;
    localparam logic [1:0] CFG_IV_HIGH  = 2'd1;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd2;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd3;

    localparam int NUM_ROUNDS = 10;

    localparam logic [7:0] RCON_TAB [0:9] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] a);
        return SBOX[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

FILE: rtl/aesctr_round.sv
`timescale 1ns / 1ps
// One cipher round together with the key schedule step that yields its round key.
module aesctr_round #(
    parameter logic [7:0] RCON = 8'h01,
    parameter bit         LAST = 1'b0
) (
    input  aesctr_pkg::t_block i_st,
    input  aesctr_pkg::t_block i_rk,
    output aesctr_pkg::t_block o_st,
    output aesctr_pkg::t_block o_rk
);
    import aesctr_pkg::*;

    logic [31:0] kt;
    t_block      nk;
    t_block      sb;
    t_block      mx;

    // key schedule: rotate, substitute and add round constant on the last word
    always_comb begin
        kt = {sbox(i_rk[103:96]), sbox(i_rk[127:120]), sbox(i_rk[119:112]),
              sbox(i_rk[111:104]) ^ RCON};
        nk[31:0]   = i_rk[31:0]   ^ kt;
        nk[63:32]  = i_rk[63:32]  ^ nk[31:0];
        nk[95:64]  = i_rk[95:64]  ^ nk[63:32];
        nk[127:96] = i_rk[127:96] ^ nk[95:64];
    end

    // SubBytes and ShiftRows, byte index = 4*column + row
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sb[(4*c + r)*8 +: 8] = sbox(i_st[(4*((c + r) % 4) + r)*8 +: 8]);
            end
        end
    end

    // MixColumns, skipped in the final round
    always_comb begin
        logic [7:0] a0, a1, a2, a3, al;
        mx = sb;
        if (!LAST) begin
            for (int c = 0; c < 4; c++) begin
                a0 = sb[(4*c)*8     +: 8];
                a1 = sb[(4*c + 1)*8 +: 8];
                a2 = sb[(4*c + 2)*8 +: 8];
                a3 = sb[(4*c + 3)*8 +: 8];
                al = a0 ^ a1 ^ a2 ^ a3;
                mx[(4*c)*8     +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                mx[(4*c + 1)*8 +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                mx[(4*c + 2)*8 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                mx[(4*c + 3)*8 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
    end

    assign o_st = mx ^ nk;
    assign o_rk = nk;

endmodule

FILE: rtl/aes128_ctr_byte_cipher.sv
`timescale 1ns / 1ps
// AES-128 counter-mode byte transform with random access by position.
//
// Input channel: i_valid / o_stall carries i_byte_position and i_data_byte.
// Output channel: o_valid / i_stall carries o_out_byte, data XOR keystream.
// Items are independent; the counter block is the IV plus position/16.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (IV low, IV high, key low, key high). Write only while the pipeline is empty.
//
// There are 13 register stages, and the first loads on the transfer edge:
// one stage for the counter add, one for the initial key addition, ten
// round stages each computing its round key alongside, one output select.
// Throughput is one byte per cycle unless the receiver stalls; the round
// keys travel down the pipe with each item, so no key setup time is needed
// after a key write.
// Reset clears all valid bits and the configuration registers to zero.
// When the receiver stalls, stages fill up behind the waiting result and
// o_stall rises only once every stage holds an item; nothing is lost.
module aes128_ctr_byte_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_byte_position,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import aesctr_pkg::*;

    localparam int LAST_RND = NUM_ROUNDS + 1;   // stage holding the cipher output
    localparam int OUT_STG  = NUM_ROUNDS + 2;

    logic [63:0] r_iv_low, r_iv_high, r_key_low, r_key_high;

    logic [OUT_STG:0] r_vld;
    logic [OUT_STG:0] en;
    t_block           r_ctr, r_key;
    t_block           r_st [1:LAST_RND];
    t_block           r_rk [1:LAST_RND];
    t_block           w_st [2:LAST_RND];
    t_block           w_rk [2:LAST_RND];
    logic [3:0]       r_pos [0:LAST_RND];
    logic [7:0]       r_dat [0:LAST_RND];
    logic [7:0]       r_out;
    logic [63:0]      n_lo;
    logic             n_carry;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv_low   <= '0;
            r_iv_high  <= '0;
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                CFG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-stage advance: a stage loads when empty or when it moves on
    always_comb begin
        en[OUT_STG] = !r_vld[OUT_STG] || !i_stall;
        for (int k = OUT_STG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[OUT_STG];
    assign o_out_byte = r_out;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k <= OUT_STG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // counter block: IV low half plus block number, carry into the high half
    assign {n_carry, n_lo} = {1'b0, r_iv_low} + {37'd0, i_byte_position[31:4]};

    // stage 0 and initial round key addition
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ctr    <= {r_iv_high + {63'd0, n_carry}, n_lo};
            r_key    <= {r_key_high, r_key_low};
            r_pos[0] <= i_byte_position[3:0];
            r_dat[0] <= i_data_byte;
        end
        if (en[1]) begin
            r_st[1]  <= r_ctr ^ r_key;
            r_rk[1]  <= r_key;
            r_pos[1] <= r_pos[0];
            r_dat[1] <= r_dat[0];
        end
    end

    // round stages
    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_rnd
        aesctr_round #(
            .RCON (RCON_TAB[g-1]),
            .LAST (g == NUM_ROUNDS)
        ) u_round (
            .i_st (r_st[g]),
            .i_rk (r_rk[g]),
            .o_st (w_st[g+1]),
            .o_rk (w_rk[g+1])
        );

        always_ff @(posedge i_clk) begin
            if (en[g+1]) begin
                r_st[g+1]  <= w_st[g+1];
                r_rk[g+1]  <= w_rk[g+1];
                r_pos[g+1] <= r_pos[g];
                r_dat[g+1] <= r_dat[g];
            end
        end
    end

    // keystream byte select and XOR
    always_ff @(posedge i_clk) begin
        if (en[OUT_STG]) begin
            r_out <= r_dat[LAST_RND] ^ r_st[LAST_RND][{r_pos[LAST_RND], 3'b000} +: 8];
        end
    end

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");

    // an input transfer lands in the first stage
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

    // back-pressure reaches the input only with every stage occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

endmodule

FILE: tb/sv/ctr_byte_checker.sv
`timescale 1ns / 1ps
module ctr_byte_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_byte_position,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import aesctr_pkg::*;

    // model register copies
    logic [63:0] iv_lo_q, iv_hi_q, key_lo_q, key_hi_q;
    logic [7:0]  expected_bytes [$];

    localparam logic [7:0] SUB [0:255] = SBOX;
    localparam logic [7:0] RC [0:9] = RCON_TAB;

    function automatic logic [7:0] gmul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 encrypt, byte i of a block at bits [8i+7:8i]
    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                  input logic [127:0] pt);
        logic [7:0] rk [0:175];
        logic [7:0] s [0:15];
        logic [7:0] t [0:15];
        logic [7:0] w [0:3];
        logic [7:0] f, a0, a1, a2, a3, al;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) w[j] = rk[(i-1)*4 + j];
            if ((i & 3) == 0) begin
                f = w[0];
                w[0] = SUB[w[1]] ^ RC[i/4 - 1];
                w[1] = SUB[w[2]];
                w[2] = SUB[w[3]];
                w[3] = SUB[f];
            end
            for (int j = 0; j < 4; j++) rk[i*4 + j] = rk[(i-4)*4 + j] ^ w[j];
        end
        for (int i = 0; i < 16; i++) s[i] = pt[8*i +: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[4*c + i] = SUB[s[4*((c+i) & 3) + i]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r + i];
        end
        for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
        return res;
    endfunction

    function automatic logic [7:0] keystream_xor(input logic [31:0] pos,
                                                 input logic [7:0] data);
        logic [64:0]  lo_sum;
        logic [63:0]  hi;
        logic [127:0] ks;
        lo_sum = {1'b0, iv_lo_q} + {37'd0, pos[31:4]};
        hi     = iv_hi_q + {63'd0, lo_sum[64]};
        ks     = aes_encrypt({key_hi_q, key_lo_q}, {hi, lo_sum[63:0]});
        return data ^ ks[8*pos[3:0] +: 8];
    endfunction

    assign o_pending = expected_bytes.size();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            iv_lo_q <= '0; iv_hi_q <= '0; key_lo_q <= '0; key_hi_q <= '0;
            o_fail_count <= 0;
            expected_bytes.delete();
        end else begin
            // input transfer: predict with registers as they stand
            if (i_valid && !i_in_stall)
                expected_bytes.push_back(keystream_xor(i_byte_position, i_data_byte));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IV_LOW:   iv_lo_q  <= i_cfg_data;
                    CFG_IV_HIGH:  iv_hi_q  <= i_cfg_data;
                    CFG_KEY_LOW:  key_lo_q <= i_cfg_data;
                    CFG_KEY_HIGH: key_hi_q <= i_cfg_data;
                endcase
            end
            // output transfer
            if (i_out_valid && !i_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected out_byte %h", i_out_byte);
                    o_fail_count <= o_fail_count + 1;
                end else if (expected_bytes[0] !== i_out_byte) begin
                    $error("out_byte expected %h actual %h", expected_bytes[0], i_out_byte);
                    o_fail_count <= o_fail_count + 1;
                    void'(expected_bytes.pop_front());
                end else begin
                    void'(expected_bytes.pop_front());
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import aesctr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_byte_position = '0;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_IV_LOW;
    logic [63:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;

    aes128_ctr_byte_cipher uut (.*);

    ctr_byte_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_byte_position,
        .i_data_byte, .i_out_valid(o_valid), .i_stall, .i_out_byte(o_out_byte),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // gap length: mostly short, now and then long
    function automatic int gap_len(input int mode);
        if (mode == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // output-side stalls
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            n = gap_len($urandom_range(0, 3) == 0 ? 0 : 1);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_all(input logic [63:0] ivl, ivh, kl, kh);
        cfg_write(CFG_IV_LOW, ivl);
        cfg_write(CFG_IV_HIGH, ivh);
        cfg_write(CFG_KEY_LOW, kl);
        cfg_write(CFG_KEY_HIGH, kh);
    endtask

    // one transfer; valid held until accepted, optional gap after
    task automatic send_byte(input logic [31:0] pos, input logic [7:0] data, input int mode);
        int n;
        i_valid         <= 1'b1;
        i_byte_position <= pos;
        i_data_byte     <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n = gap_len(mode);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [31:0] base;
        int mode;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, field extremes
        send_byte(32'd0, 8'h00, 0);
        send_byte(32'd15, 8'hff, 0);
        send_byte(32'd16, 8'h5a, 0);
        send_byte(32'hffff_ffff, 8'ha5, 0);
        drain();
        // all-ones registers
        load_all('1, '1, '1, '1);
        send_byte(32'd0, 8'h00, 0);
        send_byte(32'hffff_fff0, 8'hff, 0);
        send_byte(32'h0000_0010, 8'h81, 1);
        drain();
        // counter carry into the high half, and high half wrap
        load_all(64'hffff_ffff_ffff_fff8, 64'h0123_4567_89ab_cdef, rand64(), rand64());
        for (int i = 0; i < 8; i++) send_byte(32'h70 + 32'h10 * i, 8'(i * 37), 0);
        drain();
        load_all(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, rand64(), rand64());
        send_byte(32'd0, 8'h3c, 0);
        send_byte(32'd16, 8'hc3, 0);
        send_byte(32'hffff_ffff, 8'h00, 0);
        drain();

        // random phases: runs of consecutive positions, some scattered
        for (int ph = 0; ph < 10; ph++) begin
            load_all(ph == 9 ? 64'hffff_ffff_0000_0000 : rand64(), rand64(),
                     ph == 5 ? 64'd0 : rand64(), rand64());
            mode = (ph % 3 == 0) ? 0 : 1;
            for (int k = 0; k < 125; k++) begin
                if (k % 25 == 0) base = $urandom();
                if ($urandom_range(0, 4) == 0)
                    send_byte($urandom(), 8'($urandom()), mode);
                else
                    send_byte(base + k % 25, 8'($urandom()), mode);
            end
            drain();
        end
        if (fail_count == 0)
            $display("PASS aes128_ctr_byte_cipher");
        else
            $display("FAIL aes128_ctr_byte_cipher");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL aes128_ctr_byte_cipher");
        $finish;
    end

endmodule
